[design/albt_pkg.sv]
// ----------------------------------------------------------------------------
// albt_pkg: shared types and constants for the axial label boundary trim
// Widths of the voxel fields, configuration register codes and the
// plane store word layout.
// ----------------------------------------------------------------------------
package albt_pkg;

    // voxel field widths
    localparam int LABEL_W    = 8;
    localparam int INTEN_W    = 8;

    // configuration register widths and limits
    localparam int DIM_W      = 9;                  // width / height registers
    localparam int DEPTH_W    = 13;                 // depth register, plane counter
    localparam int MAX_DIM    = 256;
    localparam int MAX_DEPTH  = 4096;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // position counters and plane store addressing
    localparam int CNT_W      = 8;                  // column and row counters
    localparam int IDX_SUM_W  = CNT_W + DIM_W;      // row * width + column
    localparam int ADDR_W     = 16;
    localparam int MEM_DEPTH  = 1 << ADDR_W;

    // stream data widths (whole bytes)
    localparam int S_DATA_W   = LABEL_W + INTEN_W;
    localparam int M_DATA_W   = LABEL_W;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEPTH  = 2'd2
    } t_cfg_idx;

    // one plane store entry: center plane and above plane at one (x,y)
    typedef struct packed {
        logic [LABEL_W-1:0] center_label;
        logic [INTEN_W-1:0] center_inten;
        logic               above_obj;
        logic [INTEN_W-1:0] above_inten;
    } t_store;

endpackage

[design/axial_label_boundary_trim_core.sv]
// ----------------------------------------------------------------------------
// axial_label_boundary_trim_core: streaming axial boundary trim of a label volume
// Clears top and bottom boundary voxels of objects where the neighbor
// intensity along z is higher, one plane behind the input stream.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one transaction per voxel in raster order (x, then y, then z);
//   tdata = {intensity, label}, tuser = padding flag. After the last plane the
//   host sends one more plane of padding transactions to flush the pipeline.
//   Master stream: one transaction per voxel of the previous plane, tdata =
//   corrected label, tlast on the final voxel of the volume. Plane 0 inputs
//   produce no output.
//   Configuration: write width, height, depth only while the block is idle.
// Throughput
//   One voxel per cycle sustained unless the receiver stalls. A result follows
//   its input transaction through counter/stage, address multiply, store read
//   and output register. The 64K-entry plane store takes one read and one write
//   per voxel; a write-to-read bypass covers planes of a single voxel.
// Reset and stalls
//   Reset clears counters, valid bits and registers to 256x256x1. The plane
//   store is not cleared. A stalled receiver freezes the whole pipeline; no
//   transaction is lost or repeated, and input ready drops with it.
// ----------------------------------------------------------------------------
module axial_label_boundary_trim_core
    import albt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // voxel input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // [7:0] voxel_label, [15:8] voxel_intensity
    input  logic                  i_s_tuser,   // [0] is_padding
    // corrected label stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // [7:0] corrected_label
    output logic                  o_m_tlast    // last_voxel
);

    // configuration registers
    logic [DIM_W-1:0]   r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_height;
    logic [DEPTH_W-1:0] r_cfg_depth;

    // position of the incoming voxel
    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [DEPTH_W-1:0] r_plane, n_plane;

    // stage 1: position and payload
    logic               r_s1_valid;
    logic [LABEL_W-1:0] r_s1_label;
    logic [INTEN_W-1:0] r_s1_inten;
    logic [CNT_W-1:0]   r_s1_col;
    logic [CNT_W-1:0]   r_s1_row;
    logic               r_s1_first;
    logic               r_s1_last;

    // stage 2: store address
    logic               r_s2_valid;
    logic [LABEL_W-1:0] r_s2_label;
    logic [INTEN_W-1:0] r_s2_inten;
    logic [ADDR_W-1:0]  r_s2_idx;
    logic               r_s2_first;
    logic               r_s2_last;

    // stage 3: store data and trim decision
    logic               r_s3_valid;
    logic [LABEL_W-1:0] r_s3_label;
    logic [INTEN_W-1:0] r_s3_inten;
    logic [ADDR_W-1:0]  r_s3_idx;
    logic               r_s3_first;
    logic               r_s3_last;
    logic               r_s3_fwd_hit;
    t_store             r_s3_fwd;
    t_store             r_rd;

    // output register
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_last;

    // plane store
    t_store             r_mem [MEM_DEPTH];

    logic               w_adv;
    logic               w_accept;
    logic [DIM_W-1:0]   w_width;
    logic [DIM_W-1:0]   w_height;
    logic [DEPTH_W-1:0] w_depth;
    logic               w_last_col;
    logic               w_last_row;
    logic               w_plane_done;
    logic [LABEL_W-1:0] w_label;
    logic [IDX_SUM_W-1:0] w_idx_sum;
    t_store             w_cur;
    t_store             w_wr;
    logic               w_obj;
    logic               w_below;
    logic [LABEL_W-1:0] w_result;

    // whole pipeline moves unless the output register is held
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_accept   = i_s_tvalid && w_adv;

    // effective extents, out-of-range register values clamp to the legal range
    always_comb begin
        if (r_cfg_width == '0) begin
            w_width = DIM_W'(1);
        end else if (r_cfg_width > DIM_W'(MAX_DIM)) begin
            w_width = DIM_W'(MAX_DIM);
        end else begin
            w_width = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            w_height = DIM_W'(1);
        end else if (r_cfg_height > DIM_W'(MAX_DIM)) begin
            w_height = DIM_W'(MAX_DIM);
        end else begin
            w_height = r_cfg_height;
        end
        if (r_cfg_depth == '0) begin
            w_depth = DEPTH_W'(1);
        end else if (r_cfg_depth > DEPTH_W'(MAX_DEPTH)) begin
            w_depth = DEPTH_W'(MAX_DEPTH);
        end else begin
            w_depth = r_cfg_depth;
        end
    end

    // position flags of the incoming voxel
    assign w_last_col   = {1'b0, r_col} >= (w_width - DIM_W'(1));
    assign w_last_row   = {1'b0, r_row} >= (w_height - DIM_W'(1));
    assign w_plane_done = r_plane >= w_depth;

    // padding and the flush plane count as background
    assign w_label = (i_s_tuser || w_plane_done) ? '0 : i_s_tdata[LABEL_W-1:0];

    // raster counters, wrap at or past the last value
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_plane = r_plane;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                if (w_last_row) begin
                    n_row = '0;
                    if (w_plane_done) begin
                        n_plane = '0;
                    end else begin
                        n_plane = r_plane + DEPTH_W'(1);
                    end
                end else begin
                    n_row = r_row + CNT_W'(1);
                end
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    // store address of the stage 1 voxel
    assign w_idx_sum = IDX_SUM_W'(r_s1_row) * IDX_SUM_W'(w_width) + IDX_SUM_W'(r_s1_col);

    // stage 3 entry, bypassed when the previous voxel wrote the same entry
    assign w_cur   = r_s3_fwd_hit ? r_s3_fwd : r_rd;
    assign w_obj   = w_cur.center_label != '0;
    assign w_below = r_s3_label != '0;

    // trim decision on the uncorrected labels
    always_comb begin
        w_result = w_cur.center_label;
        if (w_obj && w_below && !w_cur.above_obj) begin
            if (r_s3_inten > w_cur.center_inten) begin
                w_result = '0;
            end
        end else if (w_obj && w_cur.above_obj && !w_below) begin
            if (w_cur.above_inten > w_cur.center_inten) begin
                w_result = '0;
            end
        end
    end

    // store update: current plane becomes center, center becomes above
    always_comb begin
        w_wr.center_label = r_s3_label;
        w_wr.center_inten = r_s3_inten;
        if (r_s3_first) begin
            w_wr.above_obj   = 1'b0;
            w_wr.above_inten = '0;
        end else begin
            w_wr.above_obj   = w_obj;
            w_wr.above_inten = w_cur.center_inten;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_W'(MAX_DIM);
            r_cfg_height <= DIM_W'(MAX_DIM);
            r_cfg_depth  <= DEPTH_W'(1);
            r_col        <= '0;
            r_row        <= '0;
            r_plane      <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_s3_fwd_hit <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_cfg_height <= i_cfg_data[DIM_W-1:0];
                    CFG_DEPTH:  r_cfg_depth  <= i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
            if (w_adv) begin
                r_s1_valid   <= i_s_tvalid;
                r_s2_valid   <= r_s1_valid;
                r_s3_valid   <= r_s2_valid;
                r_s3_fwd_hit <= r_s3_valid && r_s2_valid && (r_s3_idx == r_s2_idx);
                r_out_valid  <= r_s3_valid && !r_s3_first;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_label  <= w_label;
            r_s1_inten  <= i_s_tdata[S_DATA_W-1:LABEL_W];
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_first  <= r_plane == '0;
            r_s1_last   <= w_last_col && w_last_row && w_plane_done;

            r_s2_label  <= r_s1_label;
            r_s2_inten  <= r_s1_inten;
            r_s2_idx    <= w_idx_sum[ADDR_W-1:0];
            r_s2_first  <= r_s1_first;
            r_s2_last   <= r_s1_last;

            r_s3_label  <= r_s2_label;
            r_s3_inten  <= r_s2_inten;
            r_s3_idx    <= r_s2_idx;
            r_s3_first  <= r_s2_first;
            r_s3_last   <= r_s2_last;
            r_s3_fwd    <= w_wr;

            r_out_label <= w_result;
            r_out_last  <= r_s3_last;
        end
    end

    // plane store: read for stage 2, write back from stage 3
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd <= r_mem[r_s2_idx];
            if (r_s3_valid) begin
                r_mem[r_s3_idx] <= w_wr;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_label;
    assign o_m_tlast  = r_out_last;

endmodule

[design/albt_sva.sv]
// ----------------------------------------------------------------------------
// albt_sva: port-level checks for axial_label_boundary_trim_core
// Output hold under backpressure, reset behavior and input ready coupling.
// ----------------------------------------------------------------------------
module albt_sva
    import albt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [S_DATA_W-1:0]   i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_DATA_W-1:0]   o_m_tdata,
    input logic                  o_m_tlast
);

    // a held output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // a draining output register never blocks the input
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

endmodule

bind axial_label_boundary_trim_core albt_sva u_albt_sva (.*);

[tb/tb_axial_label_boundary_trim_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axial_label_boundary_trim_core: stream test of the axial boundary trim
// Streams whole label volumes, each with its padding plane, through the core
// under random idling on both stream sides. A predictor keeps its own plane
// stores and predicts every corrected label and the end-of-volume flag. Each
// output transaction is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_axial_label_boundary_trim_core;
    import albt_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned DRAIN_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_VOXELS = 600;
    localparam int unsigned REPORT_LINES  = 100;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               is_last;
    } t_trim_result;

    // DUT inputs, known from time zero
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;   // [7:0] voxel_label, [15:8] voxel_intensity
    logic                  i_s_tuser   = 1'b0; // [0] is_padding
    logic                  i_m_tready  = 1'b0;
    // DUT outputs
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_DATA_W-1:0]   o_m_tdata;          // [7:0] corrected_label
    logic                  o_m_tlast;          // last_voxel

    // predictor state: registers, plane stores, position counters
    logic [DIM_W-1:0]      geom_w = 9'd256;
    logic [DIM_W-1:0]      geom_h = 9'd256;
    logic [DEPTH_W-1:0]    geom_d = 13'd1;
    logic [LABEL_W-1:0]    center_lbl_mem [MEM_DEPTH];
    logic [INTEN_W-1:0]    center_int_mem [MEM_DEPTH];
    logic                  above_obj_mem  [MEM_DEPTH];
    logic [INTEN_W-1:0]    above_int_mem  [MEM_DEPTH];
    int unsigned           col_pos   = 0;
    int unsigned           row_pos   = 0;
    int unsigned           plane_pos = 0;

    t_trim_result          trimmed_q [$];

    // run control and statistics
    bit                    idle_en       = 1'b1;
    bit                    stall_en      = 1'b1;
    bit                    pause_pending = 1'b0;
    int unsigned           mismatch_count = 0;
    int unsigned           voxels_sent    = 0;
    int unsigned           labels_checked = 0;
    int unsigned           labels_trimmed = 0;
    int unsigned           volumes_done   = 0;
    int unsigned           cycle_count    = 0;

    axial_label_boundary_trim_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run time guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("[%0t] mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Predict one accepted voxel: one corrected label of the plane above,
    // except in plane 0 where the stores are only filled.
    task automatic predict_trim(input logic [LABEL_W-1:0] lbl_in,
                                input logic [INTEN_W-1:0] inten, input logic pad);
        int unsigned        w;
        int unsigned        h;
        int unsigned        d;
        int unsigned        addr;
        logic               last_col;
        logic               last_row;
        logic               here_obj;
        logic               above_obj;
        logic               below_obj;
        logic [LABEL_W-1:0] lbl;
        logic [LABEL_W-1:0] res;
        w = clamp_extent(geom_w, MAX_DIM);
        h = clamp_extent(geom_h, MAX_DIM);
        d = clamp_extent(geom_d, MAX_DEPTH);
        addr = (row_pos * w + col_pos) % MEM_DEPTH;
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        lbl = (pad || plane_pos >= d) ? '0 : lbl_in;

        if (plane_pos == 0) begin
            // nothing above the first plane
            above_obj_mem[addr] = 1'b0;
            above_int_mem[addr] = '0;
        end else begin
            here_obj  = (center_lbl_mem[addr] != 0);
            above_obj = above_obj_mem[addr];
            below_obj = (lbl != 0);
            res = center_lbl_mem[addr];
            if (here_obj && below_obj && !above_obj) begin
                // top boundary: brighter below trims it
                if (inten > center_int_mem[addr]) res = '0;
            end else if (here_obj && above_obj && !below_obj) begin
                // bottom boundary: brighter above trims it
                if (above_int_mem[addr] > center_int_mem[addr]) res = '0;
            end
            if (here_obj && res == 0) labels_trimmed++;
            trimmed_q.push_back('{label: res,
                                  is_last: last_col && last_row && plane_pos >= d});
            above_obj_mem[addr] = here_obj;
            above_int_mem[addr] = center_int_mem[addr];
        end
        center_lbl_mem[addr] = lbl;
        center_int_mem[addr] = inten;

        // raster position of the next voxel
        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = 0;
                if (plane_pos >= d) plane_pos = 0;
                else plane_pos = (plane_pos + 1) & 32'h1FFF;
            end else begin
                row_pos = (row_pos + 1) & 32'hFF;
            end
        end else begin
            col_pos = (col_pos + 1) & 32'hFF;
        end
    endtask

    // compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_trim_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (trimmed_q.size() == 0) begin
                flag_mismatch("result with nothing expected", o_m_tdata, 0);
            end else begin
                want = trimmed_q.pop_front();
                labels_checked++;
                if (o_m_tdata !== want.label)
                    flag_mismatch("corrected_label", o_m_tdata, want.label);
                if (o_m_tlast !== want.is_last)
                    flag_mismatch("last_voxel", o_m_tlast, want.is_last);
            end
        end
    end

    // receiver: random stall bursts while enabled
    initial begin
        @(posedge i_clk);
        forever begin
            if (stall_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  geom_w = val[DIM_W-1:0];
            CFG_HEIGHT: geom_h = val[DIM_W-1:0];
            CFG_DEPTH:  geom_d = val[DEPTH_W-1:0];
            default: ;
        endcase
    endtask

    // program the volume shape; only called with the core idle
    task automatic set_volume(input int unsigned w, input int unsigned h,
                              input int unsigned d);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DEPTH, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender stops until every pending result has left the core
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (trimmed_q.size() != 0) @(posedge i_clk);
    endtask

    // one input transaction, with an optional gap before it
    task automatic send_voxel(input logic [LABEL_W-1:0] lbl, input logic [INTEN_W-1:0] inten,
                              input logic pad, input bit allow_pause);
        if (allow_pause && trimmed_q.size() != 0
                && (pause_pending || $urandom_range(0, 249) == 0)) begin
            pause_pending = 1'b0;
            hold_until_drained();
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {inten, lbl};
        i_s_tuser  <= pad;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_trim(lbl, inten, pad);
        voxels_sent++;
    endtask

    // end of a volume: wait out every result, then let the pipeline settle
    task automatic finish_volume();
        int unsigned waited;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (trimmed_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (trimmed_q.size() != 0) begin
            flag_mismatch("results never delivered", trimmed_q.size(), 0);
            trimmed_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        volumes_done++;
    endtask

    // a whole volume of random voxels plus its flush plane
    task automatic stream_volume(input int unsigned w_reg, input int unsigned h_reg,
                                 input int unsigned d_reg, input bit allow_pause);
        int unsigned        w;
        int unsigned        h;
        int unsigned        d;
        logic [LABEL_W-1:0] lbl;
        logic               pad;
        set_volume(w_reg, h_reg, d_reg);
        w = clamp_extent(w_reg & 32'h1FF, MAX_DIM);
        h = clamp_extent(h_reg & 32'h1FF, MAX_DIM);
        d = clamp_extent(d_reg & 32'h1FFF, MAX_DEPTH);
        for (int unsigned z = 0; z <= d; z++) begin
            for (int unsigned n = 0; n < w * h; n++) begin
                if (z < d) begin
                    // about a third background, so boundaries are common
                    lbl = ($urandom_range(0, 2) == 0) ? '0 : LABEL_W'($urandom_range(1, 255));
                    pad = ($urandom_range(0, 15) == 0);
                end else begin
                    // flush plane: content must be ignored
                    lbl = LABEL_W'($urandom_range(0, 255));
                    pad = 1'($urandom_range(0, 1));
                end
                send_voxel(lbl, INTEN_W'($urandom_range(0, 255)), pad, allow_pause);
            end
        end
        finish_volume();
    endtask

    // 1x1 column: top trim, bottom trim, padding inside, lone voxel,
    // width register at 0 acting as 1
    task automatic test_single_column();
        set_volume(0, 1, 6);
        send_voxel(8'd0,   8'd0,   1'b0, 1'b0);  // background above the object
        send_voxel(8'd5,   8'd10,  1'b0, 1'b0);  // top boundary, darker than below
        send_voxel(8'd5,   8'd20,  1'b0, 1'b0);  // interior
        send_voxel(8'd7,   8'd15,  1'b0, 1'b0);  // bottom boundary, darker than above
        send_voxel(8'd9,   8'd255, 1'b1, 1'b0);  // padding inside the volume
        send_voxel(8'd255, 8'd255, 1'b0, 1'b0);  // isolated voxel on the last plane
        send_voxel(8'd200, 8'd0,   1'b0, 1'b0);  // flush, label ignored
        finish_volume();
    endtask

    // 2x1x2 row, height register at 0: extremes of label and intensity
    task automatic test_short_row();
        set_volume(2, 0, 2);
        send_voxel(8'd255, 8'd0,   1'b0, 1'b0);  // top boundary, brighter below
        send_voxel(8'd1,   8'd255, 1'b0, 1'b0);  // below it is padding
        send_voxel(8'd128, 8'd255, 1'b0, 1'b0);  // bottom boundary, darker above
        send_voxel(8'd0,   8'd0,   1'b1, 1'b0);
        send_voxel(8'd77,  8'd128, 1'b1, 1'b0);  // flush with padding flag
        send_voxel(8'd255, 8'd255, 1'b0, 1'b0);  // flush without padding flag
        finish_volume();
    endtask

    // widest row: register above range acts as 256
    task automatic test_width_extreme();
        stream_volume(511, 1, 1, 1'b0);
    endtask

    // tallest column of single voxels, height above range
    task automatic test_height_extreme();
        stream_volume(0, 300, 1, 1'b0);
    endtask

    // random small shapes with occasional odd ones and sender holds
    task automatic test_random_volumes();
        int unsigned start;
        start = voxels_sent;
        pause_pending = 1'b1;
        while (voxels_sent - start < RANDOM_VOXELS) begin
            if ($urandom_range(0, 9) == 0)
                stream_volume($urandom_range(0, 40), $urandom_range(0, 3),
                              $urandom_range(0, 4), 1'b1);
            else
                stream_volume($urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom_range(0, 5), 1'b1);
        end
    endtask

    // deep column of one voxel per plane, no idling on either side
    task automatic test_depth_extreme();
        idle_en  = 1'b0;
        stall_en = 1'b0;
        stream_volume(1, 1, 200, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_column();
        test_short_row();
        test_width_extreme();
        test_height_extreme();
        test_random_volumes();
        test_depth_extreme();

        $display("%0d volumes, %0d voxels sent, %0d labels checked, %0d trimmed",
                 volumes_done, voxels_sent, labels_checked, labels_trimmed);
        $display("shapes from single voxels to 256-wide, 256-tall and 200-deep volumes");
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
